// ===== hw/rtl/hrt_pkg.sv =====
// Package: types, register indexes and constants of the heart rate tracker.
package hrt_pkg;

   localparam int unsigned RATE_NUM = 60000;
   localparam logic [23:0] BPM_MAX_Q8 = 24'hFFFFFF;

   typedef enum logic [2:0] {
      REG_PRESENCE_FLOOR = 3'd0,
      REG_MIN_INTERVAL   = 3'd1,
      REG_MAX_INTERVAL   = 3'd2,
      REG_MIN_BPM        = 3'd3,
      REG_MAX_BPM        = 3'd4,
      REG_JUMP_LIMIT     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [17:0] ir_sample;
      logic        beat_detected;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [23:0] bpm_q8;
      logic [7:0]  bpm_average;
      logic [19:0] rmssd_q8;
      logic        beat_seen;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_HSUM, ST_HDIV, ST_HSQRT, ST_BDIV, ST_RATE,
      ST_RSUM, ST_FINISH, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch item, clear on absent finger, interval
      logic prep;       // HRV ring push, set up sums
      logic hsum_step;  // add one HRV ring entry
      logic hdiv_start;
      logic hdiv_step;
      logic sqrt_start;
      logic sqrt_step;
      logic bdiv_start;
      logic bdiv_step;
      logic rate_push;  // rate ring push, rate sum setup
      logic rsum_step;
      logic finish;     // holds and output update
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic beat;
      logic do_hrv_mean; // valid HRV push with fill count >= 2
      logic hsum_done;
      logic hdiv_done;
      logic sqrt_done;
      logic bdiv_done;
      logic rsum_done;
   } status_type;

endpackage

// ===== hw/rtl/hrt_ctrl.sv =====
// Controller: sequences one item through the datapath steps.
module hrt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  hrt_pkg::status_type sts,
   output hrt_pkg::cmd_type    cmd
);
   import hrt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (!sts.beat) state_in = ST_OUT;
            else begin
               cmd.prep = 1'b1;
               state_in = ST_HSUM;
            end
         end
         ST_HSUM: begin
            if (!sts.do_hrv_mean) begin
               cmd.bdiv_start = 1'b1;
               state_in = ST_BDIV;
            end else if (sts.hsum_done) begin
               cmd.hdiv_start = 1'b1;
               state_in = ST_HDIV;
            end else cmd.hsum_step = 1'b1;
         end
         ST_HDIV: begin
            if (sts.hdiv_done) begin
               cmd.sqrt_start = 1'b1;
               state_in = ST_HSQRT;
            end else cmd.hdiv_step = 1'b1;
         end
         ST_HSQRT: begin
            if (sts.sqrt_done) begin
               cmd.bdiv_start = 1'b1;
               state_in = ST_BDIV;
            end else cmd.sqrt_step = 1'b1;
         end
         ST_BDIV: begin
            if (sts.bdiv_done) state_in = ST_RATE;
            else cmd.bdiv_step = 1'b1;
         end
         ST_RATE: begin
            cmd.rate_push = 1'b1;
            state_in = ST_RSUM;
         end
         ST_RSUM: begin
            if (sts.rsum_done) state_in = ST_FINISH;
            else cmd.rsum_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   ast_out_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result shown while input is open");
   ast_load_prep: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_PREP)
      else $error("load did not enter prep");
   ast_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before taken");
endmodule

// ===== hw/rtl/hrt_datapath.sv =====
// Datapath: state registers, rings, divider and square root.
module hrt_datapath #(
   parameter int HRV_WINDOW  = 20,
   parameter int RATE_WINDOW = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  hrt_pkg::req_type    req_data,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [17:0]         csr_wdata,
   input  hrt_pkg::cmd_type    cmd,
   output hrt_pkg::status_type sts,
   output hrt_pkg::rsp_type    rsp_data
);
   import hrt_pkg::*;

   localparam int HW = $clog2(HRV_WINDOW);
   localparam int CW = $clog2(HRV_WINDOW + 1);
   localparam int RW = (RATE_WINDOW > 1) ? $clog2(RATE_WINDOW) : 1;
   localparam int RCW = $clog2(RATE_WINDOW + 1);
   localparam int SW = 24 + CW;                 // HRV sum width
   localparam int RSW = 8 + RCW;                // rate sum width
   localparam logic [HW-1:0] HLAST = HW'(HRV_WINDOW - 1);
   localparam logic [CW-1:0] HFULL = CW'(HRV_WINDOW);

   // configuration registers
   logic [17:0] floor_ff;
   logic [11:0] min_int_ff, max_int_ff;
   logic [7:0]  min_bpm_ff, max_bpm_ff, jump_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= 18'd4000;
         min_int_ff <= 12'd250;
         max_int_ff <= 12'd2000;
         min_bpm_ff <= 8'd20;
         max_bpm_ff <= 8'd255;
         jump_ff    <= 8'd30;
      end else if (csr_write) begin
         case (csr_index)
            REG_PRESENCE_FLOOR: floor_ff   <= csr_wdata;
            REG_MIN_INTERVAL:   min_int_ff <= csr_wdata[11:0];
            REG_MAX_INTERVAL:   max_int_ff <= csr_wdata[11:0];
            REG_MIN_BPM:        min_bpm_ff <= csr_wdata[7:0];
            REG_MAX_BPM:        max_bpm_ff <= csr_wdata[7:0];
            REG_JUMP_LIMIT:     jump_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // tracker state
   logic [HW-1:0] hidx_ff;
   logic [CW-1:0] hfill_ff;
   logic [11:0]   prev_int_ff;
   logic [7:0]    rring_ff [RATE_WINDOW];
   logic [RW-1:0] ridx_ff;
   logic [31:0]   last_ff;
   logic [23:0]   bpm_ff, prev_bpm_ff, new_bpm_ff;
   logic [7:0]    avg_ff, prev_avg_ff;
   logic [19:0]   rmssd_ff;
   logic          beat_ff, mean_ff;
   logic [31:0]   delta_ff;
   logic [23:0]   hring [HRV_WINDOW];
   logic [23:0]   hrd_ff;

   // working registers
   logic [SW-1:0]  hsum_ff;
   logic [CW-1:0]  hcnt_ff;      // entries read so far
   logic           hpend_ff;     // read data valid
   logic [HW-1:0]  hraddr_ff;
   logic [39:0]    dq_ff;        // divider quotient / dividend
   logic [32:0]    drem_ff;
   logic [31:0]    dden_ff;
   logic [5:0]     dcnt_ff;
   logic [39:0]    sv_ff;        // isqrt radicand
   logic [39:0]    sres_ff, sbit_ff;
   logic [RSW-1:0] rsum_ff;
   logic [RCW-1:0] rcnt_ff;

   logic [31:0] delta_c;
   assign delta_c = req_data.time_ms - last_ff;

   logic in_range;
   assign in_range = delta_ff > {20'd0, min_int_ff} && delta_ff < {20'd0, max_int_ff};

   logic [11:0] dabs;
   assign dabs = (delta_ff[11:0] > prev_int_ff) ? delta_ff[11:0] - prev_int_ff
                                                : prev_int_ff - delta_ff[11:0];
   logic [23:0] dsq;
   assign dsq = dabs * dabs;

   logic [CW-1:0] fill_next;
   assign fill_next = (hfill_ff < HFULL) ? hfill_ff + 1'b1 : hfill_ff;

   // HRV ring memory with registered read
   always_ff @(posedge clock) begin
      if (cmd.prep && in_range && prev_int_ff != 12'd0) hring[hidx_ff] <= dsq;
      hrd_ff <= hring[hraddr_ff];
   end

   // rate bounds: 60000 vs bound*delta (40 bits)
   logic [39:0] maxp, minp;
   assign maxp = max_bpm_ff * delta_ff;
   assign minp = min_bpm_ff * delta_ff;
   logic rate_ok_ff;

   // divider shift step
   logic [32:0] drem_sh;
   assign drem_sh = {drem_ff[31:0], dq_ff[39]};
   logic dge;
   assign dge = drem_sh >= {1'b0, dden_ff};

   // sqrt step
   logic sge;
   assign sge = sv_ff >= sres_ff + sbit_ff;

   logic [RSW-1:0] rsum_add;
   assign rsum_add = rsum_ff + RSW'(rring_ff[rcnt_ff[RW-1:0]]);

   logic [7:0] avg_new;
   assign avg_new = 8'(rsum_ff / RATE_WINDOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         hidx_ff <= '0; hfill_ff <= '0; prev_int_ff <= '0;
         for (int i = 0; i < RATE_WINDOW; i++) rring_ff[i] <= '0;
         ridx_ff <= '0; last_ff <= '0; bpm_ff <= '0; avg_ff <= '0;
         rmssd_ff <= '0;
      end else begin
         if (cmd.load) begin
            beat_ff <= req_data.beat_detected;
            if (req_data.ir_sample < floor_ff) begin
               bpm_ff <= '0; avg_ff <= '0; hfill_ff <= '0; hidx_ff <= '0;
               prev_int_ff <= '0; rmssd_ff <= '0;
            end
            delta_ff <= delta_c;
            if (req_data.beat_detected) last_ff <= req_data.time_ms;
         end
         if (cmd.prep) begin
            prev_bpm_ff <= bpm_ff;
            prev_avg_ff <= avg_ff;
            mean_ff     <= 1'b0;
            rate_ok_ff  <= delta_ff != 32'd0 && maxp > 40'(RATE_NUM)
                           && minp < 40'(RATE_NUM);
            hsum_ff <= '0; hcnt_ff <= '0; hpend_ff <= 1'b0; hraddr_ff <= '0;
            if (in_range) begin
               if (prev_int_ff != 12'd0) begin
                  hidx_ff  <= (hidx_ff == HLAST) ? '0 : hidx_ff + 1'b1;
                  hfill_ff <= fill_next;
                  mean_ff  <= fill_next >= CW'(2);
               end
               prev_int_ff <= delta_ff[11:0];
            end
         end
         // sequential sum over filled entries
         if (cmd.hsum_step) begin
            if (hpend_ff) begin
               hsum_ff <= hsum_ff + SW'(hrd_ff);
               hcnt_ff <= hcnt_ff + 1'b1;
            end
            hpend_ff  <= 1'b1;
            hraddr_ff <= (hraddr_ff == HLAST) ? hraddr_ff : hraddr_ff + 1'b1;
         end
         if (cmd.hdiv_start) begin
            dq_ff <= 40'(hsum_ff); drem_ff <= '0;
            dden_ff <= 32'(hfill_ff); dcnt_ff <= '0;
         end
         if (cmd.bdiv_start) begin
            dq_ff <= 40'(RATE_NUM) << 8; drem_ff <= '0;
            dden_ff <= delta_ff; dcnt_ff <= '0;
         end
         if (cmd.hdiv_step || cmd.bdiv_step) begin
            drem_ff <= dge ? drem_sh - {1'b0, dden_ff} : drem_sh;
            dq_ff   <= {dq_ff[38:0], dge};
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         if (cmd.sqrt_start) begin
            sv_ff <= {dq_ff[23:0], 16'd0};
            sres_ff <= '0;
            sbit_ff <= 40'd1 << 38;
         end
         if (cmd.sqrt_step) begin
            if (sge) begin
               sv_ff   <= sv_ff - (sres_ff + sbit_ff);
               sres_ff <= (sres_ff >> 1) + sbit_ff;
            end else sres_ff <= sres_ff >> 1;
            sbit_ff <= sbit_ff >> 2;
            if (sbit_ff == 40'd1) rmssd_ff <= sge ? 20'((sres_ff >> 1) + sbit_ff)
                                                  : 20'(sres_ff >> 1);
         end
         if (cmd.rate_push) begin
            new_bpm_ff <= (delta_ff == 32'd0 || dq_ff[39:24] != 16'd0) ? BPM_MAX_Q8
                                                                      : dq_ff[23:0];
            if (rate_ok_ff) begin
               rring_ff[ridx_ff] <= dq_ff[15:8];
               ridx_ff <= (32'(ridx_ff) == RATE_WINDOW - 1) ? '0 : ridx_ff + 1'b1;
            end
            rsum_ff <= '0; rcnt_ff <= '0;
         end
         if (cmd.rsum_step) begin
            rsum_ff <= rsum_add;
            rcnt_ff <= rcnt_ff + 1'b1;
         end
         if (cmd.finish) begin
            bpm_ff <= ({8'd0, prev_bpm_ff} > {8'd0, new_bpm_ff} + {8'd0, jump_ff, 8'd0})
                      ? prev_bpm_ff : new_bpm_ff;
            if (rate_ok_ff) begin
               avg_ff <= ({1'b0, prev_avg_ff} > {1'b0, avg_new} + {1'b0, jump_ff})
                         ? prev_avg_ff : avg_new;
            end else begin
               avg_ff <= ({1'b0, prev_avg_ff} > {1'b0, avg_ff} + {1'b0, jump_ff})
                         ? prev_avg_ff : avg_ff;
            end
         end
      end
   end

   assign sts.beat        = beat_ff;
   assign sts.do_hrv_mean = mean_ff;
   assign sts.hsum_done   = hcnt_ff == hfill_ff;
   assign sts.hdiv_done   = dcnt_ff == 6'd40;
   assign sts.sqrt_done   = sbit_ff == 40'd0;
   assign sts.bdiv_done   = dcnt_ff == 6'd40;
   assign sts.rsum_done   = 32'(rcnt_ff) == RATE_WINDOW;

   assign rsp_data.bpm_q8      = bpm_ff;
   assign rsp_data.bpm_average = avg_ff;
   assign rsp_data.rmssd_q8    = rmssd_ff;
   assign rsp_data.beat_seen   = beat_ff;

   ast_fill: assert property (@(posedge clock) disable iff (reset)
      hfill_ff <= HFULL)
      else $error("fill count beyond window");
   ast_idx: assert property (@(posedge clock) disable iff (reset)
      hidx_ff <= HLAST)
      else $error("hrv index out of range");
   ast_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.hdiv_step || cmd.bdiv_step) |-> dcnt_ff < 6'd40)
      else $error("divider stepped past its end");
endmodule

// ===== hw/rtl/heart_rate_and_rmssd_tracker.sv =====
// Top level of the heart rate and rMSSD tracker.
// One item in, one result out. An item without a beat skips the steps below. A beat
// item runs a 40-step restoring divide for the rate and, when it pushes a new
// HRV entry and the ring then holds two or more entries, a sum over the filled
// entries, a 40-step divide for the mean and a 20-step square root; a sum over
// the RATE_WINDOW rate ring entries follows. The divider is shared by the mean
// and the rate.
module heart_rate_and_rmssd_tracker #(
   parameter int HRV_WINDOW  = 20,
   parameter int RATE_WINDOW = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hrt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hrt_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [17:0]      csr_wdata
);
   import hrt_pkg::*;

   cmd_type    cmd;
   status_type sts;

   hrt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   hrt_datapath #(.HRV_WINDOW(HRV_WINDOW), .RATE_WINDOW(RATE_WINDOW)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .csr_write(csr_write),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_data)
   );
endmodule

// ===== sim/hrt_checker.sv =====
// Checker for the heart rate tracker: mirrors the registers, predicts each result and compares.
module hrt_checker #(
   parameter int HRV_WINDOW  = 20,
   parameter int RATE_WINDOW = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  hrt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  hrt_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [17:0]      csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               results_seen,
   output int               beats_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import hrt_pkg::*;

   // mirrored registers
   logic [17:0] floor_r;
   logic [11:0] min_iv_r, max_iv_r;
   logic [7:0]  min_bpm_r, max_bpm_r, jump_r;

   // tracker state
   logic [23:0] sq_diff[HRV_WINDOW];
   int unsigned hrv_wr, hrv_fill;
   logic [11:0] prev_iv;
   logic [7:0]  rate_hist[RATE_WINDOW];
   int unsigned rate_wr;
   logic [31:0] last_beat;
   logic [23:0] bpm_r;
   logic [7:0]  avg_r;
   logic [19:0] rmssd_r;

   rsp_type expected_rsp[$];

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // advance the tracker by one sample and return the expected result
   function automatic rsp_type track_sample(req_type r);
      logic [31:0] delta, d, rsum;
      logic [63:0] sum, q;
      logic [23:0] new_bpm, old_bpm;
      logic [7:0]  old_avg;
      rsp_type     o;
      // no finger: clear rate, average and HRV state
      if (r.ir_sample < floor_r) begin
         bpm_r = 0;
         avg_r = 0;
         hrv_fill = 0;
         hrv_wr = 0;
         prev_iv = 0;
         rmssd_r = 0;
      end
      if (r.beat_detected) begin
         old_bpm = bpm_r;
         old_avg = avg_r;
         delta = r.time_ms - last_beat;
         last_beat = r.time_ms;
         // HRV ring
         if (delta > min_iv_r && delta < max_iv_r) begin
            if (prev_iv != 0) begin
               d = (delta > prev_iv) ? delta - prev_iv : prev_iv - delta;
               sq_diff[hrv_wr] = 24'(d * d);
               hrv_wr = (hrv_wr + 1) % HRV_WINDOW;
               if (hrv_fill < HRV_WINDOW) hrv_fill++;
               if (hrv_fill >= 2) begin
                  sum = 0;
                  for (int i = 0; i < hrv_fill; i++) sum += sq_diff[i];
                  sum /= hrv_fill;
                  rmssd_r = 20'(int_sqrt(sum << 16));
               end
            end
            prev_iv = delta[11:0];
         end
         // instant rate, saturated
         if (delta == 0) begin
            new_bpm = BPM_MAX_Q8;
         end else begin
            q = (64'(RATE_NUM) << 8) / delta;
            new_bpm = (q > 64'(BPM_MAX_Q8)) ? BPM_MAX_Q8 : q[23:0];
         end
         // average ring, bounds tested on the exact ratio
         if (delta != 0 && 64'(RATE_NUM) < 64'(max_bpm_r) * delta
             && 64'(RATE_NUM) > 64'(min_bpm_r) * delta) begin
            rate_hist[rate_wr] = 8'(RATE_NUM / delta);
            rate_wr = (rate_wr + 1) % RATE_WINDOW;
            rsum = 0;
            for (int i = 0; i < RATE_WINDOW; i++) rsum += rate_hist[i];
            avg_r = 8'(rsum / RATE_WINDOW);
         end
         // hold large drops
         bpm_r = new_bpm;
         if (64'(old_bpm) > 64'(new_bpm) + (64'(jump_r) << 8)) bpm_r = old_bpm;
         if (32'(old_avg) > 32'(avg_r) + 32'(jump_r)) avg_r = old_avg;
      end
      o.bpm_q8 = bpm_r;
      o.bpm_average = avg_r;
      o.rmssd_q8 = rmssd_r;
      o.beat_seen = r.beat_detected;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         floor_r <= 18'd4000;
         min_iv_r <= 12'd250;
         max_iv_r <= 12'd2000;
         min_bpm_r <= 8'd20;
         max_bpm_r <= 8'd255;
         jump_r <= 8'd30;
         hrv_wr = 0;
         hrv_fill = 0;
         prev_iv = 0;
         for (int i = 0; i < RATE_WINDOW; i++) rate_hist[i] = 0;
         rate_wr = 0;
         last_beat = 0;
         bpm_r = 0;
         avg_r = 0;
         rmssd_r = 0;
         expected_rsp.delete();
         fail_count <= 0;
         pending <= 0;
         results_seen <= 0;
         beats_seen <= 0;
      end else begin
         // register writes
         if (csr_write) begin
            case (reg_index_type'(csr_index))
               REG_PRESENCE_FLOOR: floor_r <= csr_wdata;
               REG_MIN_INTERVAL:   min_iv_r <= csr_wdata[11:0];
               REG_MAX_INTERVAL:   max_iv_r <= csr_wdata[11:0];
               REG_MIN_BPM:        min_bpm_r <= csr_wdata[7:0];
               REG_MAX_BPM:        max_bpm_r <= csr_wdata[7:0];
               REG_JUMP_LIMIT:     jump_r <= csr_wdata[7:0];
               default: ;
            endcase
         end
         // result side
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_rsp.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("[%0t] unexpected result %h", $realtime, rsp_data);
            end else begin
               exp_r = expected_rsp.pop_front();
               if (exp_r != rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("[%0t] mismatch: bpm %h/%h avg %h/%h rmssd %h/%h beat %b/%b",
                        $realtime, exp_r.bpm_q8, rsp_data.bpm_q8, exp_r.bpm_average,
                        rsp_data.bpm_average, exp_r.rmssd_q8, rsp_data.rmssd_q8,
                        exp_r.beat_seen, rsp_data.beat_seen);
               end
            end
         end
         // item side
         if (req_valid && req_ready) begin
            expected_rsp.push_back(track_sample(req_data));
            if (req_data.beat_detected) beats_seen <= beats_seen + 1;
         end
         pending <= expected_rsp.size();
      end
   end

endmodule

// ===== sim/tb_heart_rate_and_rmssd_tracker.sv =====
// Testbench top: clock, reset, stimulus and verdict for the heart rate tracker.
module tb_heart_rate_and_rmssd_tracker;
   timeunit 1ns;
   timeprecision 1ps;
   import hrt_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock, reset;
   logic        req_valid, req_ready;
   req_type     req_data;
   logic        rsp_valid, rsp_ready;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [17:0] csr_wdata;
   int          fail_count, pending, results_seen, beats_seen;
   int          cycles = 0;
   bit          steady;
   int          stall_left;
   logic [31:0] now_ms;

   heart_rate_and_rmssd_tracker DUT (.*);

   hrt_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_write, .csr_index, .csr_wdata, .fail_count, .pending,
      .results_seen, .beats_seen
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver stalls: mostly short, a few long
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // valid stays high across back-to-back items; this task lowers it only for a gap
   task automatic send_item(logic [17:0] ir, logic beat, logic [31:0] t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{ir_sample: ir, beat_detected: beat, time_ms: t};
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic sample_after(logic [17:0] ir, logic beat, logic [31:0] dt);
      now_ms += dt;
      send_item(ir, beat, now_ms);
   endtask

   // drain, then program all registers back to back
   task automatic program_regs(logic [17:0] fl, logic [11:0] mini, logic [11:0] maxi,
                               logic [7:0] minb, logic [7:0] maxb, logic [7:0] jl);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= REG_PRESENCE_FLOOR; csr_wdata <= fl;
      @(posedge clock);
      csr_index <= REG_MIN_INTERVAL; csr_wdata <= 18'(mini);
      @(posedge clock);
      csr_index <= REG_MAX_INTERVAL; csr_wdata <= 18'(maxi);
      @(posedge clock);
      csr_index <= REG_MIN_BPM; csr_wdata <= 18'(minb);
      @(posedge clock);
      csr_index <= REG_MAX_BPM; csr_wdata <= 18'(maxb);
      @(posedge clock);
      csr_index <= REG_JUMP_LIMIT; csr_wdata <= 18'(jl);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // mostly a plausible pulse train, some noise and dropouts
   task automatic random_items(int count);
      int          kind;
      logic [17:0] ir;
      logic        beat;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 99);
         beat = ($urandom_range(0, 9) < 4);
         ir = 18'($urandom_range(20000, 262143));
         if (kind < 3) ir = 18'($urandom_range(0, 4500));
         if (kind < 85) begin
            if (beat) sample_after(ir, 1'b1, $urandom_range(300, 1400));
            else sample_after(ir, 1'b0, $urandom_range(1, 40));
         end else if (kind < 95) begin
            sample_after(18'($urandom), beat, $urandom_range(0, 5000));
         end else begin
            now_ms = $urandom;
            send_item(18'($urandom), beat, now_ms);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_ready = 1'b0;
      steady = 1'b0;
      now_ms = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bounds, zero interval, wrap, absent finger, jump hold
      sample_after(18'h3FFFF, 1'b1, 800);
      sample_after(18'h3FFFF, 1'b1, 800);
      sample_after(18'h3FFFF, 1'b1, 600);
      sample_after(18'd4000, 1'b1, 1000);
      sample_after(18'h3FFFF, 1'b1, 0);
      sample_after(18'h3FFFF, 1'b1, 250);
      sample_after(18'h3FFFF, 1'b1, 251);
      sample_after(18'h3FFFF, 1'b1, 2000);
      sample_after(18'h3FFFF, 1'b1, 1999);
      sample_after(18'h3FFFF, 1'b1, 3000);
      sample_after(18'h3FFFF, 1'b1, 235);
      sample_after(18'h3FFFF, 1'b1, 236);
      sample_after(18'h3FFFF, 1'b1, 300);
      sample_after(18'h3FFFF, 1'b1, 1900);
      sample_after(18'd3999, 1'b0, 10);
      sample_after(18'd0, 1'b1, 700);
      sample_after(18'h2AAAA, 1'b1, 700);
      sample_after(18'h15555, 1'b1, 720);
      now_ms = 32'hFFFF_FE00;
      send_item(18'h3FFFF, 1'b1, now_ms);
      sample_after(18'h3FFFF, 1'b1, 32'h400);
      sample_after(18'h3FFFF, 1'b0, 5);
      now_ms = 32'h5555_5555;
      send_item(18'h3FFFF, 1'b1, now_ms);
      now_ms = 32'hAAAA_AAAA;
      send_item(18'h3FFFF, 1'b1, now_ms);
      random_items(300);

      // wide open bounds, every drop held
      program_regs(18'd0, 12'd0, 12'd4095, 8'd0, 8'd255, 8'd0);
      random_items(300);

      // everything rejected, weakest hold; no idling in this phase
      steady = 1'b1;
      program_regs(18'h3FFFF, 12'd4095, 12'd0, 8'd255, 8'd0, 8'd255);
      random_items(200);
      steady = 1'b0;

      program_regs(18'd4000, 12'd300, 12'd1500, 8'd40, 8'd200, 8'd10);
      random_items(350);

      program_regs(18'($urandom_range(0, 30000)), 12'($urandom_range(100, 400)),
                   12'($urandom_range(1200, 4095)), 8'($urandom_range(0, 60)),
                   8'($urandom_range(120, 255)), 8'($urandom));
      random_items(350);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d results (%0d beat items) over five register settings.",
               results_seen, beats_seen);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/hrt_pkg.sv
hw/rtl/hrt_ctrl.sv
hw/rtl/hrt_datapath.sv
hw/rtl/heart_rate_and_rmssd_tracker.sv
sim/hrt_checker.sv
sim/tb_heart_rate_and_rmssd_tracker.sv
